// ===== rtl/drtp_pkg.sv =====
// Shared types, codes and constants for the dirty region transfer planner.
// No dependencies; imported by every module of the block.
package drtp_pkg;

   localparam int DIM_W    = 12;
   localparam int MODE_W   = 4;
   localparam int IVAL_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_DIM_DEFAULT    = 2048;
   localparam int COUNT_BITS_DEFAULT = 16;

   // x alignment masks, cut to coordinate width
   localparam logic [DIM_W-1:0] ALIGN_KEEP = 12'hFFC;
   localparam logic [DIM_W-1:0] ALIGN_LOW  = 12'h003;

   localparam logic [DIM_W-1:0]  DISP_WIDTH_RESET  = 12'd2048;
   localparam logic [DIM_W-1:0]  DISP_HEIGHT_RESET = 12'd2048;
   localparam logic [IVAL_W-1:0] INTERVAL_RESET     = 16'd0;
   localparam logic [MODE_W-1:0] FULL_MODE_RESET    = 4'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISP_WIDTH    = 2'd0,
      CSR_DISP_HEIGHT   = 2'd1,
      CSR_FULL_INTERVAL = 2'd2,
      CSR_FULL_MODE     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_OOB   = 2'd2
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0] req_mode;
      logic [DIM_W-1:0]  dirty_y_high;
      logic [DIM_W-1:0]  dirty_y_low;
      logic [DIM_W-1:0]  dirty_x_high;
      logic [DIM_W-1:0]  dirty_x_low;
   } req_item_type;

   typedef struct packed {
      logic              forced;
      logic [MODE_W-1:0] mode;
   } decision_type;

   typedef struct packed {
      logic              forced_full;
      logic [MODE_W-1:0] out_mode;
      logic [DIM_W-1:0]  area_h;
      logic [DIM_W-1:0]  area_w;
      logic [DIM_W-1:0]  area_y;
      logic [DIM_W-1:0]  area_x;
      status_type        status;
   } rsp_item_type;

endpackage

// ===== rtl/drtp_counter.sv =====
// Saturating update counter and forced full refresh decision.
// Depends on drtp_pkg.
module drtp_counter import drtp_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [IVAL_W-1:0] interval,
   input  logic [MODE_W-1:0] full_mode,
   input  logic [MODE_W-1:0] req_mode,
   output decision_type      decision
);

   localparam int CMP_W = (COUNT_BITS > IVAL_W) ? COUNT_BITS : IVAL_W;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_sat;
   logic                  forced;

   assign count_sat = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign forced    = (interval != '0) && (CMP_W'(count_sat) >= CMP_W'(interval));

   always_comb begin
      count_in = count_ff;
      if (advance) begin
         count_in = forced ? '0 : count_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign decision.forced = forced;
   assign decision.mode   = forced ? full_mode : req_mode;

   a_forced_clears: assert property (@(posedge clock) disable iff (reset)
      advance && forced |=> count_ff == '0)
      else $error("count not cleared after forced refresh");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !forced && count_ff != '1 |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance by one");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("count changed without a transaction");

endmodule

// ===== rtl/drtp_plan.sv =====
// Rectangle alignment, clamping and status check for one request.
// Depends on drtp_pkg; purely combinational.
module drtp_plan import drtp_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  req_item_type     item,
   input  decision_type     decision,
   input  logic [DIM_W-1:0] disp_width,
   input  logic [DIM_W-1:0] disp_height,
   output rsp_item_type     result
);

   logic [DIM_W-1:0] w;
   logic [DIM_W-1:0] h;
   logic [DIM_W-1:0] top;
   logic [DIM_W-1:0] xl;
   logic [DIM_W-1:0] xh;
   logic [DIM_W-1:0] yl;
   logic [DIM_W-1:0] yh;
   status_type       status;

   // oversized panel is used as MAX_DIM
   assign w = ({1'b0, disp_width} > (DIM_W+1)'(MAX_DIM)) ? DIM_W'(MAX_DIM) : disp_width;
   assign h = ({1'b0, disp_height} > (DIM_W+1)'(MAX_DIM)) ? DIM_W'(MAX_DIM) : disp_height;

   // last covered pixel, widened to the end of its 4-pixel group
   assign top = ((item.dirty_x_high == '0) ? '0 : item.dirty_x_high - 1'b1) | ALIGN_LOW;

   always_comb begin
      if (decision.forced) begin
         xl = '0;
         yl = '0;
         xh = w;
         yh = h;
      end else begin
         xl = item.dirty_x_low & ALIGN_KEEP;
         yl = item.dirty_y_low;
         xh = (top >= w) ? w : top + 1'b1;
         yh = item.dirty_y_high;
      end
   end

   always_comb begin
      if (xh <= xl || yh <= yl) begin
         status = ST_EMPTY;
      end else if (xl >= w || yl >= h || xh > w || yh > h) begin
         status = ST_OOB;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result.status      = status;
      result.out_mode    = decision.mode;
      result.forced_full = decision.forced;
      if (status == ST_OK) begin
         result.area_x = xl;
         result.area_y = yl;
         result.area_w = xh - xl;
         result.area_h = yh - yl;
      end else begin
         result.area_x = '0;
         result.area_y = '0;
         result.area_w = '0;
         result.area_h = '0;
      end
   end

endmodule

// ===== rtl/dirty_region_transfer_planner_unit.sv =====
// Top level of the dirty region transfer planner: CSRs, input and result registers.
// Depends on drtp_pkg, drtp_counter and drtp_plan.
//
// Plans one panel transfer per update request. A request is registered on
// acceptance, planned in the next stage and held in the result register until
// taken, so the block takes one transaction every cycle as long as results are
// accepted; that rate is set by the single update of the partial count, done
// as each request moves from the input register to the result register. Every
// interval-th request (when the interval is nonzero) is replaced by a full
// panel transfer in the configured full mode. Otherwise x is widened to 4-pixel
// groups and clamped to the panel width. Non-ok results carry zero area fields.
// CSRs are to be written only while no transaction is in flight.
module dirty_region_transfer_planner_unit import drtp_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dirty_x_low, dirty_x_high, dirty_y_low, dirty_y_high, req_mode, 4 pad bits
   input  logic [55:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // area_x, area_y, area_w, area_h, out_mode, 4 pad bits
   output logic [55:0]           rsp_tdata,
   // status, forced_full
   output logic [2:0]            rsp_tuser
);

   logic [DIM_W-1:0]  disp_width_ff;
   logic [DIM_W-1:0]  disp_height_ff;
   logic [IVAL_W-1:0] interval_ff;
   logic [MODE_W-1:0] full_mode_ff;

   logic              in_valid_ff;
   req_item_type      in_item_ff;
   logic              out_valid_ff;
   rsp_item_type      out_item_ff;
   rsp_item_type      out_item_in;

   logic              out_free;
   logic              advance;
   decision_type      decision;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_width_ff  <= DISP_WIDTH_RESET;
         disp_height_ff <= DISP_HEIGHT_RESET;
         interval_ff    <= INTERVAL_RESET;
         full_mode_ff   <= FULL_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DISP_WIDTH:    disp_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_DISP_HEIGHT:   disp_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_FULL_INTERVAL: interval_ff    <= csr_wdata[IVAL_W-1:0];
            CSR_FULL_MODE:     full_mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item_type'(req_tdata[51:0]);
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   drtp_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .interval  (interval_ff),
      .full_mode (full_mode_ff),
      .req_mode  (in_item_ff.req_mode),
      .decision  (decision)
   );

   drtp_plan #(
      .MAX_DIM (MAX_DIM)
   ) u_plan (
      .item        (in_item_ff),
      .decision    (decision),
      .disp_width  (disp_width_ff),
      .disp_height (disp_height_ff),
      .result      (out_item_in)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_item_ff.out_mode, out_item_ff.area_h,
                        out_item_ff.area_w, out_item_ff.area_y, out_item_ff.area_x};
   assign rsp_tuser  = {out_item_ff.forced_full, out_item_ff.status};

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1:0] != 2'd3)
      else $error("result carries an undefined status code");

   a_nonok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_item_ff.status != ST_OK |->
         out_item_ff.area_x == '0 && out_item_ff.area_y == '0 &&
         out_item_ff.area_w == '0 && out_item_ff.area_h == '0)
      else $error("non-ok result has nonzero area");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("waiting result changed");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for dirty_region_transfer_planner_unit.
// Depends on rtl/drtp_pkg.sv and the RTL of the block; predicts every transfer plan
// in a local model and checks each result transaction field by field.
`timescale 1ns / 1ps

module testbench;
   import drtp_pkg::*;

   localparam int PANEL_MAX   = MAX_DIM_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 200;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic [2:0]            rsp_tuser;

   dirty_region_transfer_planner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // local copy of the registers and the update counter
   logic [DIM_W-1:0]  panel_w          = DISP_WIDTH_RESET;
   logic [DIM_W-1:0]  panel_h          = DISP_HEIGHT_RESET;
   logic [IVAL_W-1:0] refresh_interval = INTERVAL_RESET;
   logic [MODE_W-1:0] full_mode        = FULL_MODE_RESET;
   logic [IVAL_W-1:0] update_count     = '0;

   req_item_type update_requests[$];
   rsp_item_type planned_transfers[$];
   req_item_type req_in_flight;

   bit  idle_on      = 1'b1;
   int  send_gap     = 0;
   int  recv_stall   = 0;
   int  hold_left    = 0;
   int  results_seen = 0;
   int  error_count  = 0;
   int  cycle_count  = 0;

   rsp_item_type got_plan;
   rsp_item_type want_plan;

   function automatic logic [DIM_W-1:0] clip_dim(logic [DIM_W-1:0] d);
      return (d > PANEL_MAX) ? DIM_W'(PANEL_MAX) : d;
   endfunction

   // advances the update counter and returns the planned transfer
   function automatic rsp_item_type plan_transfer(req_item_type r);
      logic [DIM_W-1:0] w, h;
      logic [DIM_W:0]   xl, xh, yl, yh, top;
      rsp_item_type     p;
      w  = clip_dim(panel_w);
      h  = clip_dim(panel_h);
      xl = {1'b0, r.dirty_x_low};
      xh = {1'b0, r.dirty_x_high};
      yl = {1'b0, r.dirty_y_low};
      yh = {1'b0, r.dirty_y_high};
      p  = '0;
      p.out_mode    = r.req_mode;
      p.forced_full = 1'b0;
      if (update_count != '1)
         update_count = update_count + 1'b1;
      if (refresh_interval != '0 && update_count >= refresh_interval) begin
         update_count  = '0;
         p.out_mode    = full_mode;
         p.forced_full = 1'b1;
         xl = '0;
         yl = '0;
         xh = {1'b0, w};
         yh = {1'b0, h};
      end else begin
         top = (xh != '0) ? xh - 1'b1 : '0;
         xl  = xl & {1'b0, ALIGN_KEEP};
         top = top | {1'b0, ALIGN_LOW};
         xh  = (top >= w) ? {1'b0, w} : top + 1'b1;
      end
      // empty wins over the bounds checks
      if (xh <= xl || yh <= yl)
         p.status = ST_EMPTY;
      else if (xl >= w || yl >= h || xh > w || yh > h)
         p.status = ST_OOB;
      else begin
         p.status = ST_OK;
         p.area_x = xl[DIM_W-1:0];
         p.area_y = yl[DIM_W-1:0];
         p.area_w = DIM_W'(xh - xl);
         p.area_h = DIM_W'(yh - yl);
      end
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 40);
   endfunction

   function automatic logic [DIM_W-1:0] edge_coord(int d);
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1;
         2: v = 2;
         3: v = 3;
         4: v = 4;
         5: v = d - 1;
         6: v = d;
         7: v = d + 1;
         8: v = 4092;
         default: v = 4095;
      endcase
      return DIM_W'(v);
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 11))
         0: return 12'd1;
         1: return 12'd2;
         2: return 12'd3;
         3: return 12'd4;
         4: return 12'd5;
         5: return 12'd13;
         6: return 12'd2047;
         7: return 12'd2048;
         8: return 12'd4095;
         9: return DIM_W'($urandom_range(1, 2048));
         10: return 12'd0;
         default: return DIM_W'($urandom_range(2049, 4095));
      endcase
   endfunction

   function automatic logic [IVAL_W-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0, 1: return 16'd0;
         2: return 16'd1;
         3: return 16'd2;
         4: return 16'd3;
         5: return 16'd5;
         6: return 16'd16;
         7: return 16'hFFFF;
         8: return IVAL_W'($urandom);
         default: return IVAL_W'($urandom_range(1, 60));
      endcase
   endfunction

   // rectangles inside the panel, corner values, broken ones and fully random ones
   function automatic req_item_type make_update();
      req_item_type r;
      int ew, eh, kind, xl, xh, yl, yh;
      ew   = clip_dim(panel_w);
      eh   = clip_dim(panel_h);
      kind = $urandom_range(0, 99);
      r.req_mode = MODE_W'($urandom_range(0, 15));
      if (kind < 15 || ew == 0 || eh == 0) begin
         xl = $urandom_range(0, 4095);
         xh = $urandom_range(0, 4095);
         yl = $urandom_range(0, 4095);
         yh = $urandom_range(0, 4095);
      end else if (kind < 75) begin
         xl = $urandom_range(0, ew - 1);
         xh = $urandom_range(xl + 1, ew);
         yl = $urandom_range(0, eh - 1);
         yh = $urandom_range(yl + 1, eh);
         if (kind >= 60) begin
            xl = edge_coord(ew);
            xh = edge_coord(ew);
            yl = edge_coord(eh);
            yh = edge_coord(eh);
         end
      end else if (kind < 87) begin
         xl = $urandom_range(0, ew - 1);
         xh = $urandom_range(xl + 1, ew);
         yl = $urandom_range(0, eh - 1);
         yh = $urandom_range(yl + 1, eh);
         if ($urandom_range(0, 1) == 0) begin
            xl = $urandom_range(0, 4095);
            xh = $urandom_range(0, xl);
         end else begin
            yl = $urandom_range(0, 4095);
            yh = $urandom_range(0, yl);
         end
      end else begin
         xl = $urandom_range(0, ew - 1);
         xh = $urandom_range(xl + 1, ew);
         if ($urandom_range(0, 1) == 0) begin
            yl = $urandom_range(0, eh - 1);
            yh = $urandom_range(eh + 1, 4095);
         end else begin
            yl = $urandom_range(eh, 4094);
            yh = $urandom_range(yl + 1, 4095);
         end
      end
      r.dirty_x_low  = DIM_W'(xl);
      r.dirty_x_high = DIM_W'(xh);
      r.dirty_y_low  = DIM_W'(yl);
      r.dirty_y_high = DIM_W'(yh);
      return r;
   endfunction

   task automatic queue_update(int xl, int xh, int yl, int yh, int m);
      req_item_type r;
      r.dirty_x_low  = DIM_W'(xl);
      r.dirty_x_high = DIM_W'(xh);
      r.dirty_y_low  = DIM_W'(yl);
      r.dirty_y_high = DIM_W'(yh);
      r.req_mode     = MODE_W'(m);
      update_requests.push_back(r);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         update_requests.push_back(make_update());
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DISP_WIDTH:    panel_w          = val[DIM_W-1:0];
         CSR_DISP_HEIGHT:   panel_h          = val[DIM_W-1:0];
         CSR_FULL_INTERVAL: refresh_interval = val[IVAL_W-1:0];
         CSR_FULL_MODE:     full_mode        = val[MODE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // unused upper bits of the narrow registers get random junk
   task automatic config_panel(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [IVAL_W-1:0] ival, logic [MODE_W-1:0] m);
      logic [CSR_DATA_W-DIM_W-1:0]  junk_w, junk_h;
      logic [CSR_DATA_W-MODE_W-1:0] junk_m;
      junk_w = (CSR_DATA_W-DIM_W)'($urandom);
      junk_h = (CSR_DATA_W-DIM_W)'($urandom);
      junk_m = (CSR_DATA_W-MODE_W)'($urandom);
      write_reg(CSR_DISP_WIDTH, {junk_w, w});
      write_reg(CSR_DISP_HEIGHT, {junk_h, h});
      write_reg(CSR_FULL_INTERVAL, ival);
      write_reg(CSR_FULL_MODE, {junk_m, m});
   endtask

   task automatic drain_block();
      do
         @(negedge clock);
      while (update_requests.size() != 0 || req_tvalid || planned_transfers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      if (error_count < 40)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_seen, field, got, want);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            planned_transfers.push_back(plan_transfer(req_in_flight));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (update_requests.size() != 0) begin
               req_in_flight = update_requests.pop_front();
               req_tdata  <= {4'b0000, req_in_flight};
               req_tvalid <= 1'b1;
               send_gap = idle_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_plan.status      = status_type'(rsp_tuser[1:0]);
            got_plan.forced_full = rsp_tuser[2];
            got_plan.area_x      = rsp_tdata[11:0];
            got_plan.area_y      = rsp_tdata[23:12];
            got_plan.area_w      = rsp_tdata[35:24];
            got_plan.area_h      = rsp_tdata[47:36];
            got_plan.out_mode    = rsp_tdata[51:48];
            if (planned_transfers.size() == 0) begin
               report_mismatch("unexpected transaction, status", got_plan.status, 0);
            end else begin
               want_plan = planned_transfers.pop_front();
               if (got_plan.status !== want_plan.status)
                  report_mismatch("status", got_plan.status, want_plan.status);
               if (got_plan.area_x !== want_plan.area_x)
                  report_mismatch("area_x", got_plan.area_x, want_plan.area_x);
               if (got_plan.area_y !== want_plan.area_y)
                  report_mismatch("area_y", got_plan.area_y, want_plan.area_y);
               if (got_plan.area_w !== want_plan.area_w)
                  report_mismatch("area_w", got_plan.area_w, want_plan.area_w);
               if (got_plan.area_h !== want_plan.area_h)
                  report_mismatch("area_h", got_plan.area_h, want_plan.area_h);
               if (got_plan.out_mode !== want_plan.out_mode)
                  report_mismatch("out_mode", got_plan.out_mode, want_plan.out_mode);
               if (got_plan.forced_full !== want_plan.forced_full)
                  report_mismatch("forced_full", got_plan.forced_full, want_plan.forced_full);
            end
            results_seen++;
            // long hold-offs so the block fills and stalls its input
            if (results_seen == 400 || results_seen == 900)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
               recv_stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 2048 x 2048, no forced refresh
      queue_update(0, 2048, 0, 2048, 0);
      queue_update(0, 0, 0, 1, 15);          // x high of 0 still widens to 4
      queue_update(1, 6, 3, 9, 5);           // alignment of both x bounds
      queue_update(2045, 4095, 0, 4, 1);     // x high clamped to the width
      queue_update(8, 5, 0, 4, 2);           // empty in x after widening
      queue_update(0, 8, 7, 7, 3);           // empty in y
      queue_update(0, 8, 9, 2, 4);
      queue_update(4095, 4095, 4095, 4095, 15);
      queue_update(0, 8, 2048, 2049, 6);     // y low past the panel
      queue_update(0, 8, 10, 4095, 7);       // y high past the panel
      queue_update(0, 4095, 0, 4095, 8);
      queue_update(2047, 2048, 2047, 2048, 9);
      queue_update(4092, 4095, 0, 1, 10);
      queue_update(3, 4, 0, 1, 11);
      queue_update(4, 5, 0, 1, 12);
      drain_block();

      // zero panel, every request forced
      config_panel(12'd0, 12'd0, 16'd1, 4'd15);
      queue_update(0, 4, 0, 4, 0);
      queue_update(10, 20, 10, 20, 3);
      queue_update(0, 4095, 0, 4095, 15);
      drain_block();

      // oversized width is taken as the maximum, one-line panel, every third forced
      config_panel(12'd4095, 12'd1, 16'd3, 4'd0);
      queue_update(0, 4095, 0, 1, 1);
      queue_update(0, 4, 1, 2, 2);
      queue_update(5, 9, 0, 1, 3);
      drain_block();

      for (int c = 0; c < 13; c++) begin
         config_panel(pick_dim(), pick_dim(), pick_interval(), MODE_W'($urandom_range(0, 15)));
         @(negedge clock);
         idle_on = (c % 4 != 3);
         queue_random(100);
         drain_block();
      end

      // largest interval, far from being reached
      @(negedge clock);
      idle_on = 1'b0;
      config_panel(12'd2048, 12'd2048, 16'hFFFF, 4'd15);
      queue_random(2);
      drain_block();

      repeat (8) @(posedge clock);
      if (error_count == 0 && planned_transfers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
